@@ hw/rtl/eht_pkg.sv @@
// ----------------------------------------------------------------------------
// eht_pkg
// Types, constants and helper functions shared by the ellipse hit tester.
// ----------------------------------------------------------------------------
package eht_pkg;

  localparam int COORD_W    = 32;
  localparam int AXIS_W     = 31;
  localparam int ROT_W      = 16;
  localparam int ROT_FRAC   = 14;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 32;

  localparam logic [AXIS_W-1:0]       NORM_MAX = '1;
  localparam logic signed [ROT_W-1:0] ROT_ONE  = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_SEMI_MAJOR = 3'd2,
    CFG_SEMI_MINOR = 3'd3,
    CFG_ROT_COS    = 3'd4,
    CFG_ROT_SIN    = 3'd5
  } cfg_reg_t;

  // Saturates a rotated coordinate to the signed 32-bit range and returns
  // its magnitude.
  function automatic logic [31:0] sat_mag(input logic signed [35:0] s);
    logic [31:0] m;
    if (s > 36'sh07FFFFFFF) begin
      m = 32'h7FFF_FFFF;
    end else if (s < -36'sh080000000) begin
      m = 32'h8000_0000;
    end else if (s[35]) begin
      m = 32'(-s);
    end else begin
      m = s[31:0];
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/eht_in_if.sv @@
// ----------------------------------------------------------------------------
// eht_in_if
// Query channel: a point and a tolerance per transfer.
// ----------------------------------------------------------------------------
interface eht_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [eht_pkg::COORD_W-1:0]  query_x;
  logic signed [eht_pkg::COORD_W-1:0]  query_y;
  logic        [eht_pkg::AXIS_W-1:0]   tolerance;

  modport source (output valid, query_x, query_y, tolerance, input ready);
  modport sink   (input valid, query_x, query_y, tolerance, output ready);
endinterface

@@ hw/rtl/eht_out_if.sv @@
// ----------------------------------------------------------------------------
// eht_out_if
// Result channel: hit and degenerate flags per transfer.
// ----------------------------------------------------------------------------
interface eht_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic degenerate;

  modport source (output valid, hit, degenerate, input ready);
  modport sink   (input valid, hit, degenerate, output ready);
endinterface

@@ hw/rtl/eht_div_cell.sv @@
// ----------------------------------------------------------------------------
// eht_div_cell
// One restoring division step: brings in one dividend bit, yields one
// quotient bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module eht_div_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [eht_pkg::AXIS_W-1:0]    divisor,
  input  logic [eht_pkg::AXIS_W-1:0]    rem_in,
  input  logic [eht_pkg::AXIS_W-1:0]    q_in,
  input  logic [eht_pkg::AXIS_W-1:0]    dvd_in,
  output logic [eht_pkg::AXIS_W-1:0]    rem_out,
  output logic [eht_pkg::AXIS_W-1:0]    q_out,
  output logic [eht_pkg::AXIS_W-1:0]    dvd_out
);

  logic [eht_pkg::AXIS_W:0] rem_s;
  logic [eht_pkg::AXIS_W:0] div_e;
  logic                     ge;

  assign rem_s = {rem_in, dvd_in[eht_pkg::AXIS_W-1]};
  assign div_e = {1'b0, divisor};
  assign ge    = rem_s >= div_e;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? eht_pkg::AXIS_W'(rem_s - div_e) : eht_pkg::AXIS_W'(rem_s);
      q_out   <= {q_in[eht_pkg::AXIS_W-2:0], ge};
      dvd_out <= {dvd_in[eht_pkg::AXIS_W-2:0], 1'b0};
    end
  end

endmodule

@@ hw/rtl/eht_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// eht_sqrt_cell
// One digit-by-digit square root step: takes two radicand bits and yields
// one root bit, handing remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module eht_sqrt_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad_in,
  input  logic [33:0] rem_in,
  input  logic [31:0] root_in,
  output logic [63:0] rad_out,
  output logic [33:0] rem_out,
  output logic [31:0] root_out
);

  logic [35:0] rem_s;
  logic [35:0] trial;
  logic        ge;

  assign rem_s = {rem_in, rad_in[63:62]};
  assign trial = {2'b00, root_in, 2'b01};
  assign ge    = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? 34'(rem_s - trial) : 34'(rem_s);
      root_out <= {root_in[30:0], ge};
      rad_out  <= {rad_in[61:0], 2'b00};
    end
  end

endmodule

@@ hw/rtl/ellipse_hit_tester.sv @@
// ----------------------------------------------------------------------------
// ellipse_hit_tester
// Tests whether a query point lies within a tolerance of a rotated ellipse.
//
// Software sets the center, semi-axes and rotation cosine and sine through
// the write port (cfg_we, cfg_index, cfg_data) while the block is idle.
// Each transfer on the query channel carries a point and a tolerance; each
// produces exactly one transfer on the result channel, in order.
// The datapath is a single stalling pipeline: subtract, rotate, saturate,
// a chain of 31 divider cells per axis, squaring, a chain of 32 square root
// cells per radius, and the final product compare. One query is taken every
// cycle while the receiver does not stall the result channel.
// The depth of the divider and square root chains sets the latency.
// When the receiver stalls, the result stays in the output register and
// the whole pipeline holds; query.ready falls until the result is taken.
// Reset empties the pipeline and loads the default ellipse (zero axes,
// no rotation), for which every result is a degenerate miss.
// ----------------------------------------------------------------------------
module ellipse_hit_tester #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  eht_in_if.sink                          query,
  eht_out_if.source                       result,
  input  logic                            cfg_we,
  input  logic [eht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eht_pkg::CFG_W-1:0]       cfg_data
);

  localparam int F  = COORD_FRAC_BITS;
  localparam int DW = 32 + F;
  localparam int ND = eht_pkg::DIV_STEPS;
  localparam int NS = eht_pkg::SQRT_STEPS;
  localparam logic [31:0] ONE = 32'(1) << F;

  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [30:0]        semi_major;
  logic [30:0]        semi_minor;
  logic signed [15:0] rot_cos;
  logic signed [15:0] rot_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      semi_major <= '0;
      semi_minor <= '0;
      rot_cos    <= eht_pkg::ROT_ONE;
      rot_sin    <= '0;
    end else if (cfg_we) begin
      case (eht_pkg::cfg_reg_t'(cfg_index))
        eht_pkg::CFG_CENTER_X:   center_x   <= cfg_data;
        eht_pkg::CFG_CENTER_Y:   center_y   <= cfg_data;
        eht_pkg::CFG_SEMI_MAJOR: semi_major <= cfg_data[30:0];
        eht_pkg::CFG_SEMI_MINOR: semi_minor <= cfg_data[30:0];
        eht_pkg::CFG_ROT_COS:    rot_cos    <= cfg_data[15:0];
        eht_pkg::CFG_ROT_SIN:    rot_sin    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v;
  logic out_hit;
  logic out_deg;

  assign en             = !out_v || result.ready;
  assign query.ready    = en;
  assign result.valid   = out_v;
  assign result.hit     = out_hit;
  assign result.degenerate = out_deg;

  // Stage A: offset from the center.
  logic               a_v;
  logic signed [32:0] a_vx;
  logic signed [32:0] a_vy;
  logic [30:0]        a_tol;

  // Stage B: rotation products.
  logic               b_v;
  logic signed [48:0] b_xc;
  logic signed [48:0] b_ys;
  logic signed [48:0] b_yc;
  logic signed [48:0] b_xs;
  logic [30:0]        b_tol;

  // Stage C: saturated magnitudes.
  logic               c_v;
  logic [31:0]        c_mx;
  logic [31:0]        c_my;
  logic [30:0]        c_tol;
  logic signed [49:0] sum_x;
  logic signed [49:0] sum_y;

  assign sum_x = 50'(b_xc) + 50'(b_ys);
  assign sum_y = 50'(b_yc) - 50'(b_xs);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (en) begin
      a_v <= query.valid;
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vx  <= 33'(query.query_x) - 33'(center_x);
      a_vy  <= 33'(query.query_y) - 33'(center_y);
      a_tol <= query.tolerance;
      b_xc  <= a_vx * rot_cos;
      b_ys  <= a_vy * rot_sin;
      b_yc  <= a_vy * rot_cos;
      b_xs  <= a_vx * rot_sin;
      b_tol <= a_tol;
      c_mx  <= eht_pkg::sat_mag(sum_x[49:eht_pkg::ROT_FRAC]);
      c_my  <= eht_pkg::sat_mag(sum_y[49:eht_pkg::ROT_FRAC]);
      c_tol <= b_tol;
    end
  end

  // Stage D and divider chains; index 0 of each array is the stage D register.
  logic [DW-1:0] dvx;
  logic [DW-1:0] dvy;

  assign dvx = {c_mx, F'(0)};
  assign dvy = {c_my, F'(0)};

  logic [30:0] xr [0:ND];
  logic [30:0] xq [0:ND];
  logic [30:0] xd [0:ND];
  logic [30:0] yr [0:ND];
  logic [30:0] yq [0:ND];
  logic [30:0] yd [0:ND];

  logic        sd_v    [0:ND];
  logic        sd_satx [0:ND];
  logic        sd_saty [0:ND];
  logic [31:0] sd_mx   [0:ND];
  logic [31:0] sd_my   [0:ND];
  logic [30:0] sd_tol  [0:ND];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ND; k++) begin
        sd_v[k] <= 1'b0;
      end
    end else if (en) begin
      sd_v[0] <= c_v;
      for (int k = 1; k <= ND; k++) begin
        sd_v[k] <= sd_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_satx[0] <= 32'(dvx[DW-1:31]) >= 32'(semi_major);
      sd_saty[0] <= 32'(dvy[DW-1:31]) >= 32'(semi_minor);
      xr[0]      <= 31'(dvx[DW-1:31]);
      yr[0]      <= 31'(dvy[DW-1:31]);
      xd[0]      <= dvx[30:0];
      yd[0]      <= dvy[30:0];
      xq[0]      <= '0;
      yq[0]      <= '0;
      sd_mx[0]   <= c_mx;
      sd_my[0]   <= c_my;
      sd_tol[0]  <= c_tol;
      for (int k = 1; k <= ND; k++) begin
        sd_satx[k] <= sd_satx[k-1];
        sd_saty[k] <= sd_saty[k-1];
        sd_mx[k]   <= sd_mx[k-1];
        sd_my[k]   <= sd_my[k-1];
        sd_tol[k]  <= sd_tol[k-1];
      end
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    eht_div_cell u_x (
      .clk(clk), .en(en), .divisor(semi_major),
      .rem_in(xr[k]), .q_in(xq[k]), .dvd_in(xd[k]),
      .rem_out(xr[k+1]), .q_out(xq[k+1]), .dvd_out(xd[k+1])
    );
    eht_div_cell u_y (
      .clk(clk), .en(en), .divisor(semi_minor),
      .rem_in(yr[k]), .q_in(yq[k]), .dvd_in(yd[k]),
      .rem_out(yr[k+1]), .q_out(yq[k+1]), .dvd_out(yd[k+1])
    );
  end

  // Stages E, F, G: normalized coordinates, squares, sums.
  logic        e_v, f_v, g_v;
  logic [30:0] e_nx, e_ny;
  logic [31:0] e_mx, e_my;
  logic [30:0] e_tol, f_tol, g_tol;
  logic [61:0] f_nx2, f_ny2;
  logic [63:0] f_mx2, f_my2;
  logic [63:0] g_sn, g_sm;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else if (en) begin
      e_v <= sd_v[ND];
      f_v <= e_v;
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_nx  <= sd_satx[ND] ? eht_pkg::NORM_MAX : xq[ND];
      e_ny  <= sd_saty[ND] ? eht_pkg::NORM_MAX : yq[ND];
      e_mx  <= sd_mx[ND];
      e_my  <= sd_my[ND];
      e_tol <= sd_tol[ND];
      f_nx2 <= e_nx * e_nx;
      f_ny2 <= e_ny * e_ny;
      f_mx2 <= e_mx * e_mx;
      f_my2 <= e_my * e_my;
      f_tol <= e_tol;
      g_sn  <= 64'(f_nx2) + 64'(f_ny2);
      g_sm  <= f_mx2 + f_my2;
      g_tol <= f_tol;
    end
  end

  // Square root chains; index 0 is fed from stage G.
  logic [63:0] na [0:NS];
  logic [33:0] nr [0:NS];
  logic [31:0] nt [0:NS];
  logic [63:0] ma [0:NS];
  logic [33:0] mr [0:NS];
  logic [31:0] mt [0:NS];
  logic        sq_v   [1:NS];
  logic [30:0] sq_tol [1:NS];

  assign na[0]     = g_sn;
  assign nr[0]     = '0;
  assign nt[0]     = '0;
  assign ma[0]     = g_sm;
  assign mr[0]     = '0;
  assign mt[0]     = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NS; k++) begin
        sq_v[k] <= 1'b0;
      end
    end else if (en) begin
      sq_v[1] <= g_v;
      for (int k = 2; k <= NS; k++) begin
        sq_v[k] <= sq_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_tol[1] <= g_tol;
      for (int k = 2; k <= NS; k++) begin
        sq_tol[k] <= sq_tol[k-1];
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    eht_sqrt_cell u_n (
      .clk(clk), .en(en),
      .rad_in(na[k]), .rem_in(nr[k]), .root_in(nt[k]),
      .rad_out(na[k+1]), .rem_out(nr[k+1]), .root_out(nt[k+1])
    );
    eht_sqrt_cell u_m (
      .clk(clk), .en(en),
      .rad_in(ma[k]), .rem_in(mr[k]), .root_in(mt[k]),
      .rad_out(ma[k+1]), .rem_out(mr[k+1]), .root_out(mt[k+1])
    );
  end

  // Stage H: products for the exact compare; stage I: result register.
  logic        h_v;
  logic [63:0] h_p1;
  logic [62:0] h_p2;
  logic        h_dz;
  logic        h_tm;
  logic [31:0] dist_d;
  logic [31:0] diff;
  logic [30:0] axis_min;
  logic        deg;

  assign dist_d   = nt[NS];
  assign diff     = (dist_d >= ONE) ? dist_d - ONE : ONE - dist_d;
  assign axis_min = (semi_major < semi_minor) ? semi_major : semi_minor;
  assign deg      = (semi_major == '0) || (semi_minor == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v   <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      h_v   <= sq_v[NS];
      out_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_p1    <= mt[NS] * diff;
      h_p2    <= sq_tol[NS] * dist_d;
      h_dz    <= dist_d == '0;
      h_tm    <= sq_tol[NS] >= axis_min;
      out_deg <= deg;
      out_hit <= deg ? 1'b0 : (h_dz ? h_tm : ({1'b0, h_p2} >= h_p1));
    end
  end

  a_deg_miss: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |-> !result.hit)
    else $error("degenerate result reported as hit");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    query.ready == (!result.valid || result.ready))
    else $error("query ready does not follow result flow");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(h_v) && $stable(sq_v[NS]))
    else $error("pipeline moved while stalled");

endmodule
